// ===== rtl/mwc8_pkg.sv =====
`timescale 1ns / 1ps

package mwc8_pkg;

  // input command codes
  localparam logic CMD_RESEED = 1'b0;
  localparam logic CMD_NEXT   = 1'b1;

  // generator constants
  localparam logic [15:0] MULT_A        = 16'd228;
  localparam int          WARMUP_STEPS  = 24;
  localparam int          WORD_STEPS    = 4;
  localparam int          CNT_W         = 5;
  localparam logic [6:0]  SEED_CARRY_MASK = 7'h7F;
  localparam logic [7:0]  CARRY_RESET   = 8'd1;

  typedef logic [CNT_W-1:0] step_cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WARM,
    ST_GEN,
    ST_HOLD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_seed;
    logic step;
    logic capture;
    logic capture_live;
  } dp_cmd_t;

endpackage

// ===== rtl/mwc8_dp.sv =====
`timescale 1ns / 1ps

module mwc8_dp (
  input  logic               clk,
  input  logic               rst,
  input  mwc8_pkg::dp_cmd_t  cmd,
  input  logic [31:0]        seed,
  output logic [31:0]        random_word
);

  logic [7:0]  x0;
  logic [7:0]  x1;
  logic [7:0]  x2;
  logic [7:0]  carry;
  logic [31:0] acc;
  logic [15:0] prod;
  logic [15:0] t_sum;
  logic [7:0]  out_byte;

  // one byte step
  assign prod     = {8'h00, x2} * mwc8_pkg::MULT_A;
  assign out_byte = (x2 ^ x1) + (x0 ^ prod[15:8]);
  assign t_sum    = prod + {8'h00, carry};

  always_ff @(posedge clk) begin
    if (rst) begin
      x0    <= 8'h00;
      x1    <= 8'h00;
      x2    <= 8'h00;
      carry <= mwc8_pkg::CARRY_RESET;
    end else if (cmd.load_seed) begin
      x0    <= seed[7:0];
      x1    <= seed[15:8];
      x2    <= seed[23:16];
      carry <= {1'b0, seed[30:24] & mwc8_pkg::SEED_CARRY_MASK} | 8'h01;
    end else if (cmd.step) begin
      x2    <= x1;
      x1    <= x0;
      x0    <= t_sum[7:0];
      carry <= t_sum[15:8];
    end
  end

  // collector keeps all four bytes so a delayed capture still has the first one
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      acc <= {acc[23:0], out_byte};
    end
    if (cmd.capture) begin
      if (cmd.capture_live) begin
        random_word <= {acc[23:0], out_byte};
      end else begin
        random_word <= acc;
      end
    end
  end

endmodule

// ===== rtl/mwc8_ctrl.sv =====
`timescale 1ns / 1ps

module mwc8_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  output logic               out_valid,
  input  logic               out_stall,
  output mwc8_pkg::dp_cmd_t  cmd
);

  mwc8_pkg::state_t    state;
  mwc8_pkg::state_t    state_next;
  mwc8_pkg::step_cnt_t cnt;
  logic                accept;
  logic                out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      mwc8_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (command == mwc8_pkg::CMD_NEXT) ? mwc8_pkg::ST_GEN
                                                       : mwc8_pkg::ST_WARM;
        end
      end
      mwc8_pkg::ST_WARM: begin
        if (cnt == '0) begin
          state_next = mwc8_pkg::ST_IDLE;
        end
      end
      mwc8_pkg::ST_GEN: begin
        if (cnt == '0) begin
          state_next = out_free ? mwc8_pkg::ST_IDLE : mwc8_pkg::ST_HOLD;
        end
      end
      mwc8_pkg::ST_HOLD: begin
        if (out_free) begin
          state_next = mwc8_pkg::ST_IDLE;
        end
      end
      default: state_next = mwc8_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall         = 1'b1;
    cmd.load_seed    = 1'b0;
    cmd.step         = 1'b0;
    cmd.capture      = 1'b0;
    cmd.capture_live = 1'b0;
    case (state)
      mwc8_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_seed = accept && (command == mwc8_pkg::CMD_RESEED);
      end
      mwc8_pkg::ST_WARM: begin
        cmd.step = 1'b1;
      end
      mwc8_pkg::ST_GEN: begin
        cmd.step         = 1'b1;
        cmd.capture      = (cnt == '0) && out_free;
        cmd.capture_live = 1'b1;
      end
      mwc8_pkg::ST_HOLD: begin
        cmd.capture = out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mwc8_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= (command == mwc8_pkg::CMD_NEXT) ? mwc8_pkg::step_cnt_t'(mwc8_pkg::WORD_STEPS - 1)
                                               : mwc8_pkg::step_cnt_t'(mwc8_pkg::WARMUP_STEPS - 1);
      end else if (cnt != '0) begin
        cnt <= cnt - mwc8_pkg::step_cnt_t'(1);
      end
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/mwc8_lag3_xx_prng.sv =====
`timescale 1ns / 1ps
// next word: accepted, then four byte steps; the word is captured into the
// output register with the last step, or from the collector after a stall
// reseed: seed load on accept, then 24 warm-up steps, no word
// one byte step a cycle through the single constant multiplier sets the rate
// rst (synchronous): lags cleared, carry set to one, output register empty

module mwc8_lag3_xx_prng (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [31:0] seed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] random_word
);

  // seed load, step and capture commands from the sequencer to the lag/carry datapath
  mwc8_pkg::dp_cmd_t dp_cmd;

  // sequencer: counts steps of a warm-up or a word and owns the output valid
  mwc8_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (dp_cmd)
  );

  // datapath: lag bytes, carry, byte collector and output word register
  mwc8_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dp_cmd),
    .seed        (seed),
    .random_word (random_word)
  );

endmodule

// ===== rtl/mwc8_chk.sv =====
`timescale 1ns / 1ps

module mwc8_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        command,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] random_word
);

  // a held word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(random_word))
    else $error("output word changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // reseed yields no word
  a_reseed_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == mwc8_pkg::CMD_RESEED && !out_valid |=> !out_valid)
    else $error("word shown after reseed");

  // next word ready after four steps when the output was empty
  a_next_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == mwc8_pkg::CMD_NEXT && !out_valid |-> ##5 out_valid)
    else $error("next word late");

endmodule

bind mwc8_lag3_xx_prng mwc8_chk u_chk (.*);
